// ----- src/alubcd_pkg.sv -----
package alubcd_pkg;

    localparam int unsigned BYTE_W = 8;
    localparam int unsigned OP_W   = 3;
    localparam int unsigned CORR_W = 4;

    localparam int unsigned S_TDATA_W = 32;
    localparam int unsigned M_TDATA_W = 24;

    localparam logic [BYTE_W-1:0] SIGN_BIT = 8'h80;

    // op codes; anything else keeps the sum register
    localparam logic [OP_W-1:0] OP_AND  = 3'd0;
    localparam logic [OP_W-1:0] OP_XOR  = 3'd1;
    localparam logic [OP_W-1:0] OP_OR   = 3'd2;
    localparam logic [OP_W-1:0] OP_SHR  = 3'd3;
    localparam logic [OP_W-1:0] OP_SUM  = 3'd4;
    localparam logic [OP_W-1:0] OP_NONE = 3'd5;

    // correction control bit positions
    localparam int unsigned CORR_ADD_LO = 0;
    localparam int unsigned CORR_ADD_HI = 1;
    localparam int unsigned CORR_SUB_LO = 2;
    localparam int unsigned CORR_SUB_HI = 3;

    typedef struct packed {
        logic              load_accumulator;
        logic [BYTE_W-1:0] bus_value;
        logic              decimal_sub;
        logic              decimal_add;
        logic              carry_in;
        logic [BYTE_W-1:0] b_operand;
        logic [BYTE_W-1:0] a_operand;
        logic [OP_W-1:0]   op;
    } alu_req_t;

    // latched outcome of the first phase
    typedef struct packed {
        logic [BYTE_W-1:0] sum;
        logic              binary_carry;
        logic              decimal_carry;
        logic              overflow;
        logic [CORR_W-1:0] corr;
    } phase_one_t;

endpackage

// ----- src/alubcd_phase_one.sv -----
module alubcd_phase_one (
    input  alubcd_pkg::alu_req_t              req,
    input  logic                              decimal_enable,
    input  logic [alubcd_pkg::BYTE_W-1:0]     sum_prev,
    output alubcd_pkg::phase_one_t            result
);

    logic [alubcd_pkg::BYTE_W-1:0] g;
    logic [alubcd_pkg::BYTE_W-1:0] p;
    logic [alubcd_pkg::BYTE_W-1:0] x;
    logic [alubcd_pkg::BYTE_W:0]   c;
    logic [alubcd_pkg::BYTE_W-1:0] sum;
    logic [alubcd_pkg::BYTE_W-1:0] sum_sel;
    logic                          daa;
    logic                          dsa;
    logic                          lo_t1;
    logic                          lo_t2;
    logic                          hi_t1;
    logic                          hi_t2;
    logic                          half;

    assign g   = req.a_operand & req.b_operand;
    assign p   = req.a_operand | req.b_operand;
    assign x   = req.a_operand ^ req.b_operand;
    assign daa = req.decimal_add & decimal_enable;
    assign dsa = req.decimal_sub & decimal_enable;

    // ripple adder; decimal add forces the carry out of the low nibble
    always_comb begin
        c[0]  = req.carry_in;
        sum   = '0;
        lo_t1 = 1'b0;
        lo_t2 = 1'b0;
        for (int n = 0; n < alubcd_pkg::BYTE_W; n++) begin
            sum[n]  = x[n] ^ c[n];
            c[n+1]  = g[n] | (p[n] & c[n]);
            if (n == 3) begin
                lo_t1 = (g[2] | x[3]) & (c[1] | x[2] | g[1] | x[1]);
                lo_t2 = p[2] & g[1] & c[1];
                if (daa && (lo_t1 || lo_t2)) begin
                    c[n+1] = 1'b1;
                end
            end
        end
    end

    assign hi_t1 = (x[7] | g[6]) & (c[5] | g[5] | x[5] | x[6]);
    assign hi_t2 = x[6] & g[5] & c[5];
    assign half  = c[4];

    always_comb begin
        case (req.op)
            alubcd_pkg::OP_AND: sum_sel = g;
            alubcd_pkg::OP_XOR: sum_sel = x;
            alubcd_pkg::OP_OR:  sum_sel = p;
            alubcd_pkg::OP_SHR: sum_sel = {1'b0, g[alubcd_pkg::BYTE_W-1:1]};
            alubcd_pkg::OP_SUM: sum_sel = sum;
            default:            sum_sel = sum_prev;
        endcase
    end

    assign result.sum           = sum_sel;
    assign result.binary_carry  = c[8];
    assign result.decimal_carry = daa & (hi_t1 | hi_t2);
    assign result.overflow      = (c[7] & ((p & alubcd_pkg::SIGN_BIT) == '0))
                                | (~c[7] & c[8]);
    assign result.corr[alubcd_pkg::CORR_ADD_LO] = daa & half;
    assign result.corr[alubcd_pkg::CORR_ADD_HI] = daa;
    assign result.corr[alubcd_pkg::CORR_SUB_LO] = dsa & ~half;
    assign result.corr[alubcd_pkg::CORR_SUB_HI] = dsa;

endmodule

// ----- src/alubcd_correct.sv -----
module alubcd_correct (
    input  alubcd_pkg::phase_one_t            latched,
    input  logic [alubcd_pkg::BYTE_W-1:0]     bus_value,
    output logic                              acr,
    output logic [alubcd_pkg::BYTE_W-1:0]     corrected
);

    logic                          daal;
    logic                          daah;
    logic                          dsal;
    logic                          dsah;
    logic [alubcd_pkg::BYTE_W-1:0] r;
    logic [alubcd_pkg::BYTE_W-1:0] f;

    assign acr  = latched.binary_carry | latched.decimal_carry;
    assign r    = latched.sum;
    assign daal = latched.corr[alubcd_pkg::CORR_ADD_LO];
    assign daah = latched.corr[alubcd_pkg::CORR_ADD_HI] & acr;
    assign dsal = latched.corr[alubcd_pkg::CORR_SUB_LO];
    assign dsah = latched.corr[alubcd_pkg::CORR_SUB_HI] & ~acr;

    // flip mask that adds or subtracts six per nibble
    assign f[0] = 1'b0;
    assign f[1] = dsal | daal;
    assign f[2] = (~r[1] & daal) | (r[1] & dsal);
    assign f[3] = ((~r[1] | ~r[2]) & dsal) | ((r[1] | r[2]) & daal);
    assign f[4] = 1'b0;
    assign f[5] = daah | dsah;
    assign f[6] = (~r[5] & daah) | (r[5] & dsah);
    assign f[7] = ((r[5] | r[6]) & daah) | ((~r[5] | ~r[6]) & dsah);

    assign corrected = bus_value ^ f;

endmodule

// ----- src/eight_bit_alu_with_decimal_adjust_core.sv -----
// Channel   Dir  Width  Contents
// s_axis    in   32     op, a_operand, b_operand, carry_in, decimal_add,
//                       decimal_sub, bus_value, load_accumulator
// m_axis    out  24     sum_result, carry_out, overflow, accumulator
// cfg       in   1      decimal_enable
//
// One request a cycle while the result is not stalled; a request passes the input
// register, then both ALU phases run combinationally before the result register,
// and the ALU state updates as the result register loads.
// Reset clears the ALU state and sets decimal_enable.
// A stalled result holds the result register; the input register then takes a
// request only while empty, and s_tready stays low while it holds one.
module eight_bit_alu_with_decimal_adjust_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic        cfg_wr_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [2:0] op, [10:3] a_operand, [18:11] b_operand, [19] carry_in,
    // [20] decimal_add, [21] decimal_sub, [29:22] bus_value,
    // [30] load_accumulator, [31] zero
    input  logic [31:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [7:0] sum_result, [8] carry_out, [9] overflow, [17:10] accumulator,
    // [23:18] zero
    output logic [23:0] m_tdata
);

    alubcd_pkg::alu_req_t          req_reg;
    logic                          req_valid_reg;
    logic                          decimal_enable_reg;
    logic                          advance;

    alubcd_pkg::phase_one_t        latch_reg;
    alubcd_pkg::phase_one_t        latch_next;
    logic [alubcd_pkg::BYTE_W-1:0] acc_reg;
    logic [alubcd_pkg::BYTE_W-1:0] acc_next;
    logic [alubcd_pkg::BYTE_W-1:0] corrected;
    logic                          acr;

    logic                          m_tvalid_reg;
    logic [23:0]                   m_tdata_reg;

    assign advance  = req_valid_reg && (!m_tvalid_reg || m_tready);
    assign s_tready = !req_valid_reg || advance;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    alubcd_phase_one u_phase_one (
        .req            (req_reg),
        .decimal_enable (decimal_enable_reg),
        .sum_prev       (latch_reg.sum),
        .result         (latch_next)
    );

    alubcd_correct u_correct (
        .latched   (latch_next),
        .bus_value (req_reg.bus_value),
        .acr       (acr),
        .corrected (corrected)
    );

    assign acc_next = req_reg.load_accumulator ? corrected : acc_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            decimal_enable_reg <= 1'b1;
        end else if (cfg_wr_en) begin
            decimal_enable_reg <= cfg_wr_data;
        end
    end

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            req_valid_reg <= 1'b0;
        end else if (s_tready) begin
            req_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            req_reg <= alubcd_pkg::alu_req_t'(s_tdata[30:0]);
        end
    end

    // ALU state and result register advance together
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            latch_reg    <= '0;
            acc_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (advance) begin
                latch_reg    <= latch_next;
                acc_reg      <= acc_next;
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            m_tdata_reg <= {6'd0, acc_next, latch_next.overflow, acr, latch_next.sum};
        end
    end

endmodule

// ----- dv/testbench.sv -----
`timescale 1ns / 100ps

module testbench;

    localparam int unsigned LATENCY_CYCLES = 2;
    localparam int unsigned QUIET_LIMIT    = 2000;
    localparam int unsigned LONG_HOLD      = 300;
    localparam int unsigned PHASES         = 6;
    localparam int unsigned PHASE_ITEMS    = 175;
    localparam bit [PHASES-1:0] PHASE_DEC_EN = 6'b101010;

    // [7:0] sum_result, [8] carry_out, [9] overflow, [17:10] accumulator
    typedef struct packed {
        logic [alubcd_pkg::BYTE_W-1:0] accumulator;
        logic                          overflow;
        logic                          carry_out;
        logic [alubcd_pkg::BYTE_W-1:0] sum_result;
    } alu_res_t;

    typedef struct {
        alubcd_pkg::alu_req_t req;
        bit                   known;
        alu_res_t             res;
    } vector_t;

    logic        aclk;
    logic        aresetn;
    logic        cfg_wr_en;
    logic        cfg_wr_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;

    eight_bit_alu_with_decimal_adjust_core u_top (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    // shadow of the ALU state
    logic                          dec_en_q     = 1'b1;
    logic [alubcd_pkg::BYTE_W-1:0] sum_q        = '0;
    logic                          bin_carry_q  = 1'b0;
    logic                          dec_carry_q  = 1'b0;
    logic                          ovf_q        = 1'b0;
    logic [alubcd_pkg::CORR_W-1:0] corr_q       = '0;
    logic [alubcd_pkg::BYTE_W-1:0] acc_q        = '0;

    vector_t  directed[$];
    vector_t  known_results[$];
    alu_res_t results_due[$];

    int  mismatches   = 0;
    int  quiet_cycles = 0;
    int  tx_mode      = 0;
    int  rx_mode      = 0;
    int  stall_left   = 0;
    bit  long_hold    = 1'b0;

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    function automatic alubcd_pkg::alu_req_t mk_req(logic [alubcd_pkg::OP_W-1:0] op,
                                                    logic [7:0] a, logic [7:0] b,
                                                    logic cin, logic da, logic ds,
                                                    logic [7:0] bus, logic ld);
        alubcd_pkg::alu_req_t r;
        r.op               = op;
        r.a_operand        = a;
        r.b_operand        = b;
        r.carry_in         = cin;
        r.decimal_add      = da;
        r.decimal_sub      = ds;
        r.bus_value        = bus;
        r.load_accumulator = ld;
        return r;
    endfunction

    function automatic alu_res_t mk_res(logic [7:0] sum, logic carry, logic ovf,
                                        logic [7:0] acc);
        alu_res_t r;
        r.sum_result  = sum;
        r.carry_out   = carry;
        r.overflow    = ovf;
        r.accumulator = acc;
        return r;
    endfunction

    // one ALU cycle: adder with decimal carry forcing, then nibble correction
    function automatic alu_res_t alu_cycle(alubcd_pkg::alu_req_t r);
        logic [alubcd_pkg::BYTE_W-1:0] g, p, x, s, co_v, f;
        logic                          c, co, daa, dsa, dc7, h, acr;
        logic                          daal, daah, dsal, dsah;
        alu_res_t                      res;
        daa = r.decimal_add & dec_en_q;
        dsa = r.decimal_sub & dec_en_q;
        g   = r.a_operand & r.b_operand;
        p   = r.a_operand | r.b_operand;
        x   = r.a_operand ^ r.b_operand;
        c   = r.carry_in;
        s   = '0;
        co_v = '0;
        dc7 = 1'b0;
        for (int n = 0; n < alubcd_pkg::BYTE_W; n++) begin
            co   = g[n] | (p[n] & c);
            s[n] = x[n] ^ c;
            // decimal add forces the half carry
            if (n == 3 && daa && ((((g[2] | x[3]) & (co_v[0] | x[2] | g[1] | x[1])) |
                                   (p[2] & g[1] & co_v[0])) == 1'b1))
                co = 1'b1;
            if (n == 7)
                dc7 = daa & (((x[7] | g[6]) & (co_v[4] | g[5] | x[5] | x[6])) |
                             (x[6] & g[5] & co_v[4]));
            co_v[n] = co;
            c       = co;
        end

        case (r.op)
            alubcd_pkg::OP_AND:  sum_q = g;
            alubcd_pkg::OP_XOR:  sum_q = x;
            alubcd_pkg::OP_OR:   sum_q = p;
            alubcd_pkg::OP_SHR:  sum_q = g >> 1;
            alubcd_pkg::OP_SUM:  sum_q = s;
            default:             sum_q = sum_q;
        endcase

        h           = co_v[3];
        bin_carry_q = co_v[7];
        dec_carry_q = dc7;
        ovf_q       = (co_v[6] & ((p & alubcd_pkg::SIGN_BIT) == '0)) | (~co_v[6] & co_v[7]);
        corr_q[alubcd_pkg::CORR_ADD_LO] = daa & h;
        corr_q[alubcd_pkg::CORR_ADD_HI] = daa;
        corr_q[alubcd_pkg::CORR_SUB_LO] = dsa & ~h;
        corr_q[alubcd_pkg::CORR_SUB_HI] = dsa;

        acr  = bin_carry_q | dec_carry_q;
        daal = corr_q[alubcd_pkg::CORR_ADD_LO];
        daah = corr_q[alubcd_pkg::CORR_ADD_HI] & acr;
        dsal = corr_q[alubcd_pkg::CORR_SUB_LO];
        dsah = corr_q[alubcd_pkg::CORR_SUB_HI] & ~acr;
        f    = '0;
        f[1] = dsal | daal;
        f[2] = (~sum_q[1] & daal) | (sum_q[1] & dsal);
        f[3] = ((~sum_q[1] | ~sum_q[2]) & dsal) | ((sum_q[1] | sum_q[2]) & daal);
        f[5] = daah | dsah;
        f[6] = (~sum_q[5] & daah) | (sum_q[5] & dsah);
        f[7] = ((sum_q[5] | sum_q[6]) & daah) | ((~sum_q[5] | ~sum_q[6]) & dsah);
        if (r.load_accumulator)
            acc_q = r.bus_value ^ f;

        res.sum_result  = sum_q;
        res.carry_out   = acr;
        res.overflow    = ovf_q;
        res.accumulator = acc_q;
        return res;
    endfunction

    function automatic logic [7:0] rand_bcd();
        return {4'($urandom_range(0, 9)), 4'($urandom_range(0, 9))};
    endfunction

    function automatic alubcd_pkg::alu_req_t rand_request();
        alubcd_pkg::alu_req_t r;
        int                   kind;
        kind = $urandom_range(0, 99);
        r.op               = alubcd_pkg::OP_SUM;
        r.a_operand        = rand_bcd();
        r.b_operand        = rand_bcd();
        r.carry_in         = 1'($urandom_range(0, 1));
        r.decimal_add      = 1'b0;
        r.decimal_sub      = 1'b0;
        r.load_accumulator = 1'($urandom_range(0, 7) != 0);
        if (kind < 40) begin
            r.decimal_add = 1'b1;
            r.decimal_sub = 1'($urandom_range(0, 15) == 0);
        end else if (kind < 65) begin
            // subtract as add of the complement
            r.b_operand   = ~r.b_operand;
            r.decimal_sub = 1'b1;
        end else begin
            r.op               = 3'($urandom_range(0, 7));
            r.a_operand        = 8'($urandom_range(0, 255));
            r.b_operand        = 8'($urandom_range(0, 255));
            r.decimal_add      = 1'($urandom_range(0, 1));
            r.decimal_sub      = 1'($urandom_range(0, 1));
            r.load_accumulator = 1'($urandom_range(0, 1));
        end
        if (kind < 65 && $urandom_range(0, 1) == 0)
            r.bus_value = 8'(r.a_operand + r.b_operand + r.carry_in);
        else
            r.bus_value = 8'($urandom_range(0, 255));
        return r;
    endfunction

    function automatic int draw_gap(int mode);
        if (mode == 0)
            return 0;
        if (mode == 1)
            return ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
        return ($urandom_range(0, 15) == 0) ? $urandom_range(8, 40) : $urandom_range(0, 2);
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        mismatches++;
        $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
    endtask

    // offer one request; keep tvalid up when the next follows without a gap
    task automatic push_request(vector_t v, bit pause_after);
        int gap;
        known_results.push_back(v);
        s_tvalid <= 1'b1;
        s_tdata  <= {1'b0, v.req};
        do @(posedge aclk); while (!s_tready);
        gap = pause_after ? 0 : draw_gap(tx_mode);
        if (pause_after || gap > 0)
            s_tvalid <= 1'b0;
        repeat (gap) @(posedge aclk);
    endtask

    // step past the last accepting edge before looking at the queue
    task automatic drain();
        @(posedge aclk);
        while (results_due.size() != 0)
            @(posedge aclk);
        repeat (LATENCY_CYCLES + 2) @(posedge aclk);
    endtask

    task automatic write_dec_enable(bit value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        dec_en_q = value;
    endtask

    // request and result handshakes, plus the watchdog
    always @(posedge aclk) begin
        vector_t  tag;
        alu_res_t want, got;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                tag  = known_results.pop_front();
                want = alu_cycle(alubcd_pkg::alu_req_t'(s_tdata[30:0]));
                if (tag.known)
                    want = tag.res;
                results_due.push_back(want);
            end
            if (m_tvalid && m_tready) begin
                got = alu_res_t'(m_tdata[17:0]);
                if (results_due.size() == 0) begin
                    report_mismatch("result with none due", int'(got), 0);
                end else begin
                    want = results_due.pop_front();
                    if (got.sum_result != want.sum_result)
                        report_mismatch("sum_result", int'(got.sum_result),
                                        int'(want.sum_result));
                    if (got.carry_out != want.carry_out)
                        report_mismatch("carry_out", int'(got.carry_out),
                                        int'(want.carry_out));
                    if (got.overflow != want.overflow)
                        report_mismatch("overflow", int'(got.overflow),
                                        int'(want.overflow));
                    if (got.accumulator != want.accumulator)
                        report_mismatch("accumulator", int'(got.accumulator),
                                        int'(want.accumulator));
                end
            end
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("status: fail");
                $finish;
            end
        end
    end

    // result side: random stalls, one long hold-off on request
    initial begin
        wait (aresetn);
        forever begin
            @(posedge aclk);
            if (stall_left > 0) begin
                m_tready <= 1'b0;
                stall_left--;
            end else if (long_hold) begin
                long_hold  = 1'b0;
                stall_left = LONG_HOLD - 1;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                stall_left = draw_gap(rx_mode);
            end
        end
    end

    initial begin
        aclk        = 1'b0;
        aresetn     = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        m_tready    = 1'b0;

        directed.push_back('{mk_req(alubcd_pkg::OP_AND, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0,
                                    8'h00, 1'b1), 1'b1,
                             mk_res(8'h00, 1'b0, 1'b0, 8'h00)});
        directed.push_back('{mk_req(alubcd_pkg::OP_SUM, 8'hFF, 8'h01, 1'b0, 1'b0, 1'b0,
                                    8'hFF, 1'b1), 1'b1,
                             mk_res(8'h00, 1'b1, 1'b0, 8'hFF)});
        directed.push_back('{mk_req(alubcd_pkg::OP_SUM, 8'h7F, 8'h01, 1'b0, 1'b0, 1'b0,
                                    8'h00, 1'b0), 1'b1,
                             mk_res(8'h80, 1'b0, 1'b1, 8'hFF)});
        directed.push_back('{mk_req(alubcd_pkg::OP_SUM, 8'h80, 8'h80, 1'b0, 1'b0, 1'b0,
                                    8'h00, 1'b0), 1'b1,
                             mk_res(8'h00, 1'b1, 1'b1, 8'hFF)});
        directed.push_back('{mk_req(alubcd_pkg::OP_XOR, 8'hA5, 8'hFF, 1'b0, 1'b0, 1'b0,
                                    8'h5A, 1'b1), 1'b0, '0});
        directed.push_back('{mk_req(alubcd_pkg::OP_OR, 8'h0F, 8'hF0, 1'b1, 1'b0, 1'b0,
                                    8'h00, 1'b0), 1'b0, '0});
        directed.push_back('{mk_req(alubcd_pkg::OP_SHR, 8'hFF, 8'hFF, 1'b1, 1'b0, 1'b0,
                                    8'h80, 1'b1), 1'b0, '0});
        directed.push_back('{mk_req(alubcd_pkg::OP_NONE, 8'h12, 8'h34, 1'b0, 1'b0, 1'b0,
                                    8'h01, 1'b1), 1'b0, '0});
        directed.push_back('{mk_req(3'd6, 8'hFF, 8'h01, 1'b1, 1'b0, 1'b0,
                                    8'h00, 1'b0), 1'b0, '0});
        directed.push_back('{mk_req(3'd7, 8'h00, 8'hFF, 1'b1, 1'b1, 1'b1,
                                    8'hFF, 1'b1), 1'b0, '0});
        directed.push_back('{mk_req(alubcd_pkg::OP_SUM, 8'hFF, 8'hFF, 1'b1, 1'b0, 1'b0,
                                    8'hFF, 1'b1), 1'b0, '0});
        directed.push_back('{mk_req(alubcd_pkg::OP_SUM, 8'h00, 8'h00, 1'b1, 1'b0, 1'b0,
                                    8'h01, 1'b1), 1'b0, '0});
        // decimal add: digit carry, byte carry, carry in
        directed.push_back('{mk_req(alubcd_pkg::OP_SUM, 8'h09, 8'h01, 1'b0, 1'b1, 1'b0,
                                    8'h0A, 1'b1), 1'b0, '0});
        directed.push_back('{mk_req(alubcd_pkg::OP_SUM, 8'h99, 8'h01, 1'b0, 1'b1, 1'b0,
                                    8'h9A, 1'b1), 1'b0, '0});
        directed.push_back('{mk_req(alubcd_pkg::OP_SUM, 8'h58, 8'h46, 1'b1, 1'b1, 1'b0,
                                    8'h9F, 1'b1), 1'b0, '0});
        directed.push_back('{mk_req(alubcd_pkg::OP_SUM, 8'h99, 8'h99, 1'b1, 1'b1, 1'b0,
                                    8'h33, 1'b1), 1'b0, '0});
        // decimal subtract with and without borrow
        directed.push_back('{mk_req(alubcd_pkg::OP_SUM, 8'h12, 8'hFE, 1'b1, 1'b0, 1'b1,
                                    8'h11, 1'b1), 1'b0, '0});
        directed.push_back('{mk_req(alubcd_pkg::OP_SUM, 8'h00, 8'hFE, 1'b1, 1'b0, 1'b1,
                                    8'hFF, 1'b1), 1'b0, '0});
        directed.push_back('{mk_req(alubcd_pkg::OP_SUM, 8'h10, 8'hF6, 1'b0, 1'b0, 1'b1,
                                    8'h06, 1'b1), 1'b0, '0});
        // both decimal requests together, decimal on a logic op, no load
        directed.push_back('{mk_req(alubcd_pkg::OP_SUM, 8'h45, 8'h55, 1'b0, 1'b1, 1'b1,
                                    8'hA5, 1'b1), 1'b0, '0});
        directed.push_back('{mk_req(alubcd_pkg::OP_AND, 8'hFF, 8'h0F, 1'b1, 1'b1, 1'b0,
                                    8'hFF, 1'b1), 1'b0, '0});
        directed.push_back('{mk_req(alubcd_pkg::OP_NONE, 8'h38, 8'h48, 1'b0, 1'b1, 1'b0,
                                    8'h80, 1'b1), 1'b0, '0});
        directed.push_back('{mk_req(alubcd_pkg::OP_SUM, 8'h55, 8'h55, 1'b0, 1'b1, 1'b0,
                                    8'hFF, 1'b0), 1'b0, '0});

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        tx_mode = 1;
        rx_mode = 1;
        foreach (directed[i])
            push_request(directed[i], i == directed.size() - 1);

        for (int ph = 0; ph < PHASES; ph++) begin
            drain();
            write_dec_enable(PHASE_DEC_EN[ph]);
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                vector_t v;
                if (i % 25 == 0) begin
                    tx_mode = $urandom_range(0, 2);
                    rx_mode = $urandom_range(0, 2);
                end
                // hold the result side and keep offering until the input stalls
                if (ph == 2 && i == 30) begin
                    long_hold = 1'b1;
                    tx_mode   = 0;
                end
                v.req   = rand_request();
                v.known = 1'b0;
                v.res   = '0;
                push_request(v, i == PHASE_ITEMS - 1);
            end
        end

        drain();
        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
